/* hw/rtl/bwnf_pkg.sv */
package bwnf_pkg;

	localparam int MAX_WINDOW = 31;
	localparam int HIST_W     = MAX_WINDOW;
	localparam int HIST_IDX_W = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int WIN_W      = 5;
	localparam int ONES_W     = 5;
	localparam int S_TDATA_W  = 8;
	localparam int M_TDATA_W  = 8;
	localparam int CFG_DATA_W = 5;

	localparam logic [WIN_W-1:0] WIN_MIN   = WIN_W'(3);
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);

	typedef enum logic {
		REG_MODE   = 1'b0,
		REG_WINDOW = 1'b1
	} reg_index_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	typedef enum logic {
		MODE_MAJORITY = 1'b0,
		MODE_GLITCH   = 1'b1
	} filter_mode_t;

	// run scanner status back to the control
	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] run;
	} scan_stat_t;

endpackage

/* hw/rtl/bit_window_noise_filter.sv */
// bit_window_noise_filter: debounce of a one-bit switch sample stream.
// input stream s_*: one beat is a sample (tuser op = sample) or a clear
// (tuser op = clear, history and count emptied, result 0 / 0).
// output stream m_*: one beat per input beat, filtered level and the count
// of ones now held in the window.
// cfg_*: register writes (index 0 mode, index 1 window size), always ready;
// writing the window size empties the history. write only while idle.
// a clear, a majority-mode sample, or a glitch-mode sample equal to the
// newest stored bit goes from idle straight to apply, which loads the result.
// a glitch-mode sample that differs walks the run of equal newest bits one
// bit per cycle in the run scanner (at most window bits), then goes to apply.
// one item is in flight at a time; s_tready is high again from the edge that
// loads the result into the output register.
// a stalled receiver holds the result in the output register; the next
// item is accepted meanwhile and waits for the register before finishing.
// reset: history and count empty, mode majority, window size 8.
module bit_window_noise_filter
	import bwnf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // [0] sample, rest zero
	input  logic                  s_tuser,   // [0] op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // [0] filtered, [5:1] ones_seen, rest zero
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

	state_t            state_q;
	logic [HIST_W-1:0] hist_q;
	logic [CNT_W-1:0]  count_q;
	logic              mode_q;
	logic [WIN_W-1:0]  ws_q;
	logic              bit_q;
	logic              clear_q;
	logic              m_tvalid_q;
	logic              filt_q;
	logic [ONES_W-1:0] ones_q;

	logic [WIN_W-1:0]      win;
	logic [WIN_W-1:0]      half;
	logic [HIST_W-1:0]     trim;
	logic [HIST_W-1:0]     shifted;
	logic [HIST_W-1:0]     inv_mask;
	logic                  top_bit;
	logic [CNT_W-1:0]      new_cnt;
	logic                  level;
	logic                  in_beat;
	logic                  out_free;
	logic                  scan_start;
	scan_stat_t            scan_stat;

	always_comb begin
		if (ws_q < WIN_MIN) begin
			win = WIN_MIN;
		end else if (int'(ws_q) > MAX_WINDOW) begin
			win = WIN_W'(MAX_WINDOW);
		end else begin
			win = ws_q;
		end
	end

	assign half = win >> 1;

	always_comb begin
		for (int k = 0; k < HIST_W; k++) begin
			trim[k]     = hist_q[k] & ((k + 1) < int'(win));
			inv_mask[k] = k < int'(scan_stat.run);
		end
	end

	assign top_bit = hist_q[HIST_IDX_W'(win - WIN_W'(1))];
	assign shifted = {trim[HIST_W-2:0], bit_q};
	assign new_cnt = count_q - CNT_W'(top_bit) + CNT_W'(bit_q);
	assign level   = (mode_q == MODE_GLITCH) ? shifted[HIST_IDX_W'(half)]
	                                          : (new_cnt >= CNT_W'(half));

	assign s_tready  = (state_q == ST_IDLE);
	assign in_beat   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	assign scan_start = in_beat && (s_tuser == OP_SAMPLE) && (mode_q == MODE_GLITCH)
	                    && (s_tdata[0] != hist_q[0]);

	bwnf_run_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.hist   (hist_q),
		.win    (win),
		.stat   (scan_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			hist_q     <= '0;
			count_q    <= '0;
			mode_q     <= MODE_MAJORITY;
			ws_q       <= WIN_RESET;
			bit_q      <= 1'b0;
			clear_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			filt_q     <= 1'b0;
			ones_q     <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MODE: begin
						mode_q <= cfg_data[0];
					end
					REG_WINDOW: begin
						ws_q    <= cfg_data[WIN_W-1:0];
						hist_q  <= '0;
						count_q <= '0;
					end
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						bit_q   <= s_tdata[0];
						clear_q <= (s_tuser == OP_CLEAR);
						state_q <= scan_start ? ST_SCAN : ST_APPLY;
					end
				end
				ST_SCAN: begin
					if (scan_stat.done) begin
						// short run counts as a glitch: flip it back
						if (scan_stat.run <= CNT_W'(half)) begin
							hist_q <= hist_q ^ inv_mask;
							if (hist_q[0]) begin
								count_q <= count_q - scan_stat.run;
							end else begin
								count_q <= count_q + scan_stat.run;
							end
						end
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (clear_q) begin
							hist_q  <= '0;
							count_q <= '0;
							filt_q  <= 1'b0;
							ones_q  <= '0;
						end else begin
							hist_q  <= shifted;
							count_q <= new_cnt;
							filt_q  <= level;
							ones_q  <= ONES_W'(new_cnt);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'({ones_q, filt_q});

endmodule

/* hw/rtl/bwnf_run_scan.sv */
module bwnf_run_scan
	import bwnf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HIST_W-1:0] hist,
	input  logic [WIN_W-1:0]  win,
	output scan_stat_t        stat
);

	logic              busy_q;
	logic [HIST_W-1:0] sh_q;
	logic [WIN_W-1:0]  idx_q;
	logic [CNT_W-1:0]  run_q;
	logic              newest_q;
	logic              step;

	// one history bit examined per cycle, oldest side reached last
	assign step = busy_q && (idx_q < win) && (sh_q[0] == newest_q);

	assign stat.done = busy_q && !step;
	assign stat.run  = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			sh_q     <= '0;
			idx_q    <= '0;
			run_q    <= '0;
			newest_q <= 1'b0;
		end else if (start) begin
			busy_q   <= 1'b1;
			sh_q     <= hist >> 1;
			idx_q    <= WIN_W'(1);
			run_q    <= CNT_W'(1);
			newest_q <= hist[0];
		end else if (step) begin
			sh_q  <= sh_q >> 1;
			idx_q <= idx_q + WIN_W'(1);
			run_q <= run_q + CNT_W'(1);
		end else begin
			busy_q <= 1'b0;
		end
	end

endmodule

/* hw/rtl/bwnf_checker.sv */
module bwnf_checker
	import bwnf_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// one item at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

	// a new result only appears while the input side is closed
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without an item in flight");

	// clear gives an all-zero result when the output is free
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_CLEAR) && !m_tvalid
		|-> ##2 (m_tvalid && (m_tdata[5:0] == 6'd0)))
		else $error("clear did not give a zero result");

endmodule

bind bit_window_noise_filter bwnf_checker u_bwnf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
